// ===== src/pbnc_pkg.sv =====
`default_nettype none

package pbnc_pkg;

    // Default sizing of the block
    localparam int PALETTE_SIZE_DEF = 256;
    localparam int WEIGHT_BITS_DEF  = 12;

    // Field widths
    localparam int COLOR_W = 8;
    localparam int RGB_W   = 3 * COLOR_W;
    localparam int NORM_W  = 18;
    localparam int ENTRY_W = RGB_W + NORM_W;
    localparam int PCT_W   = 7;

    // Blend register values
    localparam logic [PCT_W-1:0] PERCENT_RESET = 7'd66;
    localparam logic [PCT_W-1:0] PERCENT_MAX   = 7'd100;

    // Item kinds
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // Controls from the sequencer to the distance unit
    typedef struct packed {
        logic search;
        logic clear;
    } ctrl_t;

endpackage

`default_nettype wire

// ===== src/pbnc_if.sv =====
`default_nettype none

// Input item channel: palette loads and blend queries
interface pbnc_item_if;
    logic                           valid;
    logic                           ready;
    logic                           kind;
    logic [pbnc_pkg::COLOR_W-1:0]   entry_index;
    logic [pbnc_pkg::COLOR_W-1:0]   red;
    logic [pbnc_pkg::COLOR_W-1:0]   green;
    logic [pbnc_pkg::COLOR_W-1:0]   blue;
    logic [pbnc_pkg::COLOR_W-1:0]   top_color;
    logic [pbnc_pkg::COLOR_W-1:0]   bottom_color;

    modport source (
        output valid, kind, entry_index, red, green, blue, top_color, bottom_color,
        input  ready
    );

    modport sink (
        input  valid, kind, entry_index, red, green, blue, top_color, bottom_color,
        output ready
    );
endinterface

// Result channel: nearest palette index
interface pbnc_result_if;
    logic                           valid;
    logic                           ready;
    logic [pbnc_pkg::COLOR_W-1:0]   blended_color;

    modport source (
        output valid, blended_color,
        input  ready
    );

    modport sink (
        input  valid, blended_color,
        output ready
    );
endinterface

`default_nettype wire

// ===== src/palette_blend_nearest_color.sv =====
`default_nettype none

// Nearest palette color to a blend of two palette entries.
//
// Channels: item (sink) carries loads (kind 0) and queries (kind 1); result
// (source) carries one blended_color per query. Loads give no result.
// cfg_we/cfg_wdata write filter_percent, the top color's weight in percent
// (values above 100 act as 100). Write it only while the block is idle.
//
// A load is written to the palette as it is accepted. A query runs from
// acceptance to result valid through two palette reads and a mix step on the
// shared three-lane multiplier, then one palette entry per cycle through the
// same multiplier, an error stage and a compare stage. The single palette
// read port sets the one-entry-per-cycle scan rate. No new item is taken until
// a query leaves its drain step; the next one can be taken in the same cycle as the result appears.
//
// Reset leaves the palette undefined: load every entry before the first
// query. filter_percent resets to 66. The result sits in an output register;
// the next item is taken while it waits, but a finished query holds in its
// drain step until the previous result has been taken.
module palette_blend_nearest_color #(
    parameter int PALETTE_SIZE = pbnc_pkg::PALETTE_SIZE_DEF,
    parameter int WEIGHT_BITS  = pbnc_pkg::WEIGHT_BITS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    pbnc_item_if.sink                           item,
    pbnc_result_if.source                       result,
    input  wire logic                           cfg_we,
    input  wire logic [pbnc_pkg::PCT_W-1:0]     cfg_wdata
);

    localparam int CW          = pbnc_pkg::COLOR_W;
    localparam int PCT_W       = pbnc_pkg::PCT_W;
    localparam int IDX_W       = $clog2(PALETTE_SIZE);
    localparam int MIX_W       = CW + WEIGHT_BITS;
    localparam int PROD_W      = MIX_W + CW;
    localparam int W1_W        = WEIGHT_BITS + 1;
    localparam int RECIP_LOW   = 2 * PCT_W;
    localparam int RECIP_K     = WEIGHT_BITS + RECIP_LOW;
    localparam int RECIP_W     = WEIGHT_BITS + 8;
    localparam longint RECIP_L = ((longint'(1) << RECIP_K) + longint'(pbnc_pkg::PERCENT_MAX)
                                 - longint'(1)) / longint'(pbnc_pkg::PERCENT_MAX);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);
    localparam longint W1_RESET_L = (longint'(pbnc_pkg::PERCENT_RESET) << WEIGHT_BITS)
                                    / longint'(pbnc_pkg::PERCENT_MAX);
    localparam logic [W1_W-1:0] W1_RESET = W1_W'(W1_RESET_L);
    localparam logic [W1_W-1:0] W2_RESET = W1_W'((longint'(1) << WEIGHT_BITS) - W1_RESET_L);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PALETTE_SIZE - 1);
    localparam logic [CW:0] SIZE_LIM = (CW+1)'(PALETTE_SIZE);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MIX_T = 3'd1;
    localparam logic [2:0] ST_MIX_B = 3'd2;
    localparam logic [2:0] ST_MIX_S = 3'd3;
    localparam logic [2:0] ST_SCAN  = 3'd4;
    localparam logic [2:0] ST_DRAIN = 3'd5;

    logic [2:0]                     state_reg;
    logic [2:0]                     state_next;
    logic [PCT_W-1:0]               pct_reg;
    logic [W1_W-1:0]                w1_reg;
    logic [W1_W-1:0]                w2_reg;
    logic [PCT_W-1:0]               pct_sat;
    logic [PCT_W+RECIP_W-1:0]       w1_prod;
    logic [IDX_W-1:0]               scan_idx_reg;
    logic [IDX_W-1:0]               scan_idx_next;
    logic [IDX_W-1:0]               bot_idx_reg;
    logic [IDX_W-1:0]               bot_idx_next;
    logic                           top_oob_reg;
    logic                           top_oob_next;
    logic                           bot_oob_reg;
    logic                           bot_oob_next;
    logic [MIX_W-1:0]               mix_r_reg;
    logic [MIX_W-1:0]               mix_g_reg;
    logic [MIX_W-1:0]               mix_b_reg;
    logic [MIX_W-1:0]               mix_r_next;
    logic [MIX_W-1:0]               mix_g_next;
    logic [MIX_W-1:0]               mix_b_next;
    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic [CW-1:0]                  out_color_reg;
    logic [CW-1:0]                  out_color_next;
    logic                           out_load;
    logic                           accept;
    logic                           wr_en;
    logic [pbnc_pkg::NORM_W-1:0]    load_norm;
    logic [pbnc_pkg::ENTRY_W-1:0]   wr_data;
    logic                           rd_en;
    logic [IDX_W-1:0]               rd_addr;
    logic [pbnc_pkg::ENTRY_W-1:0]   rd_data;
    logic [pbnc_pkg::RGB_W-1:0]     rd_rgb;
    logic [pbnc_pkg::NORM_W-1:0]    rd_norm;
    pbnc_pkg::ctrl_t                ctrl;
    logic [pbnc_pkg::RGB_W-1:0]     op_rgb;
    logic [MIX_W-1:0]               op_red;
    logic [MIX_W-1:0]               op_green;
    logic [MIX_W-1:0]               op_blue;
    logic [PROD_W-1:0]              red_prod;
    logic [PROD_W-1:0]              green_prod;
    logic [PROD_W-1:0]              blue_prod;
    logic                           busy;
    logic [IDX_W-1:0]               best_idx;

    // Blend weights: w1 = pct * 2^WEIGHT_BITS / 100 by reciprocal multiply
    assign pct_sat = (pct_reg > pbnc_pkg::PERCENT_MAX) ? pbnc_pkg::PERCENT_MAX : pct_reg;
    assign w1_prod = {{RECIP_W{1'b0}}, pct_sat} * {{PCT_W{1'b0}}, RECIP};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pct_reg <= pbnc_pkg::PERCENT_RESET;
            w1_reg  <= W1_RESET;
            w2_reg  <= W2_RESET;
        end
        else
        begin
            if (cfg_we)
            begin
                pct_reg <= cfg_wdata;
            end
            w1_reg <= w1_prod[RECIP_LOW +: W1_W];
            w2_reg <= (W1_W'(1) << WEIGHT_BITS) - w1_reg;
        end
    end

    // Palette storage: rgb over squared norm
    assign load_norm = pbnc_pkg::NORM_W'({{CW{1'b0}}, item.red} * {{CW{1'b0}}, item.red})
                     + pbnc_pkg::NORM_W'({{CW{1'b0}}, item.green} * {{CW{1'b0}}, item.green})
                     + pbnc_pkg::NORM_W'({{CW{1'b0}}, item.blue} * {{CW{1'b0}}, item.blue});
    assign wr_data = {item.red, item.green, item.blue, load_norm};

    pbnc_palette_mem #(
        .DEPTH   (PALETTE_SIZE)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (item.entry_index[IDX_W-1:0]),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_rgb  = rd_data[pbnc_pkg::ENTRY_W-1 -: pbnc_pkg::RGB_W];
    assign rd_norm = rd_data[pbnc_pkg::NORM_W-1:0];

    pbnc_dist_unit #(
        .WEIGHT_BITS (WEIGHT_BITS),
        .IDX_W       (IDX_W)
    ) u_dist (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .op_rgb     (op_rgb),
        .op_red     (op_red),
        .op_green   (op_green),
        .op_blue    (op_blue),
        .op_norm    (rd_norm),
        .op_idx     (scan_idx_reg),
        .red_prod   (red_prod),
        .green_prod (green_prod),
        .blue_prod  (blue_prod),
        .busy       (busy),
        .best_idx   (best_idx)
    );

    assign item.ready = (state_reg == ST_IDLE);
    assign accept     = item.valid && item.ready;

    // Sequencer: write loads; for a query mix the two colors, then scan the palette from the top down
    always_comb
    begin
        state_next    = state_reg;
        scan_idx_next = scan_idx_reg;
        bot_idx_next  = bot_idx_reg;
        top_oob_next  = top_oob_reg;
        bot_oob_next  = bot_oob_reg;
        mix_r_next    = mix_r_reg;
        mix_g_next    = mix_g_reg;
        mix_b_next    = mix_b_reg;
        wr_en         = 1'b0;
        rd_en         = 1'b0;
        rd_addr       = '0;
        ctrl          = '0;
        op_rgb        = rd_rgb;
        op_red        = mix_r_reg;
        op_green      = mix_g_reg;
        op_blue       = mix_b_reg;
        out_load      = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (item.kind == pbnc_pkg::KIND_QUERY)
                    begin
                        rd_en        = 1'b1;
                        rd_addr      = item.top_color[IDX_W-1:0];
                        top_oob_next = ({1'b0, item.top_color} >= SIZE_LIM);
                        bot_oob_next = ({1'b0, item.bottom_color} >= SIZE_LIM);
                        bot_idx_next = item.bottom_color[IDX_W-1:0];
                        state_next   = ST_MIX_T;
                    end
                    else
                    begin
                        wr_en = ({1'b0, item.entry_index} < SIZE_LIM);
                    end
                end
            end
            ST_MIX_T:
            begin
                op_rgb     = top_oob_reg ? '0 : rd_rgb;
                op_red     = MIX_W'(w1_reg);
                op_green   = MIX_W'(w1_reg);
                op_blue    = MIX_W'(w1_reg);
                rd_en      = 1'b1;
                rd_addr    = bot_idx_reg;
                state_next = ST_MIX_B;
            end
            ST_MIX_B:
            begin
                op_rgb     = bot_oob_reg ? '0 : rd_rgb;
                op_red     = MIX_W'(w2_reg);
                op_green   = MIX_W'(w2_reg);
                op_blue    = MIX_W'(w2_reg);
                mix_r_next = red_prod[MIX_W-1:0];
                mix_g_next = green_prod[MIX_W-1:0];
                mix_b_next = blue_prod[MIX_W-1:0];
                state_next = ST_MIX_S;
            end
            ST_MIX_S:
            begin
                mix_r_next    = mix_r_reg + red_prod[MIX_W-1:0];
                mix_g_next    = mix_g_reg + green_prod[MIX_W-1:0];
                mix_b_next    = mix_b_reg + blue_prod[MIX_W-1:0];
                ctrl.clear    = 1'b1;
                rd_en         = 1'b1;
                rd_addr       = LAST_IDX;
                scan_idx_next = LAST_IDX;
                state_next    = ST_SCAN;
            end
            ST_SCAN:
            begin
                ctrl.search = 1'b1;
                if (scan_idx_reg == '0)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    rd_en         = 1'b1;
                    rd_addr       = scan_idx_reg - 1'b1;
                    scan_idx_next = scan_idx_reg - 1'b1;
                end
            end
            ST_DRAIN:
            begin
                if (!busy && (!out_valid_reg || result.ready))
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register: load a finished query, drop on handshake
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_color_next = out_color_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_color_next = CW'(best_idx);
        end
        else if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_idx_reg  <= scan_idx_next;
        bot_idx_reg   <= bot_idx_next;
        top_oob_reg   <= top_oob_next;
        bot_oob_reg   <= bot_oob_next;
        mix_r_reg     <= mix_r_next;
        mix_g_reg     <= mix_g_next;
        mix_b_reg     <= mix_b_next;
        out_color_reg <= out_color_next;
    end

    assign result.valid         = out_valid_reg;
    assign result.blended_color = out_color_reg;

    // A new result only comes out of the drain step
    a_result_from_drain: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result.valid) |-> ($past(state_reg) == ST_DRAIN))
        else $error("result raised outside drain");

    // The search pipeline is empty whenever new items are taken
    a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !busy)
        else $error("search pipeline busy in idle");

    // The scan walks down one entry per cycle
    a_scan_step: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_SCAN) && ($past(state_reg) == ST_SCAN))
        |-> (scan_idx_reg == $past(scan_idx_reg) - 1'b1))
        else $error("scan index skipped");

    // A pending result is never overwritten
    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.ready) |=> (result.valid && $stable(out_color_reg)))
        else $error("pending result lost");

endmodule

`default_nettype wire

// ===== src/pbnc_palette_mem.sv =====
`default_nettype none

module pbnc_palette_mem #(
    parameter int DEPTH = pbnc_pkg::PALETTE_SIZE_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]           wr_addr,
    input  wire logic [pbnc_pkg::ENTRY_W-1:0]       wr_data,
    input  wire logic                               rd_en,
    input  wire logic [$clog2(DEPTH)-1:0]           rd_addr,
    output logic      [pbnc_pkg::ENTRY_W-1:0]       rd_data
);

    logic [pbnc_pkg::ENTRY_W-1:0] mem [DEPTH];
    logic [pbnc_pkg::ENTRY_W-1:0] rd_data_reg;

    // Write one entry, read one entry with registered data
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== src/pbnc_dist_unit.sv =====
`default_nettype none

module pbnc_dist_unit #(
    parameter int WEIGHT_BITS = pbnc_pkg::WEIGHT_BITS_DEF,
    parameter int IDX_W       = 8
) (
    input  wire logic                                           clk,
    input  wire logic                                           rst_n,
    input  wire pbnc_pkg::ctrl_t                                ctrl,
    input  wire logic [pbnc_pkg::RGB_W-1:0]                     op_rgb,
    input  wire logic [pbnc_pkg::COLOR_W+WEIGHT_BITS-1:0]       op_red,
    input  wire logic [pbnc_pkg::COLOR_W+WEIGHT_BITS-1:0]       op_green,
    input  wire logic [pbnc_pkg::COLOR_W+WEIGHT_BITS-1:0]       op_blue,
    input  wire logic [pbnc_pkg::NORM_W-1:0]                    op_norm,
    input  wire logic [IDX_W-1:0]                               op_idx,
    output logic      [2*pbnc_pkg::COLOR_W+WEIGHT_BITS-1:0]     red_prod,
    output logic      [2*pbnc_pkg::COLOR_W+WEIGHT_BITS-1:0]     green_prod,
    output logic      [2*pbnc_pkg::COLOR_W+WEIGHT_BITS-1:0]     blue_prod,
    output logic                                                busy,
    output logic      [IDX_W-1:0]                               best_idx
);

    localparam int CW     = pbnc_pkg::COLOR_W;
    localparam int MIX_W  = CW + WEIGHT_BITS;
    localparam int PROD_W = MIX_W + CW;
    localparam int DOT_W  = PROD_W + 2;
    localparam int SH_W   = pbnc_pkg::NORM_W + WEIGHT_BITS - 1;
    localparam int ERR_W  = WEIGHT_BITS + 19;

    logic [PROD_W-1:0]              red_prod_reg;
    logic [PROD_W-1:0]              green_prod_reg;
    logic [PROD_W-1:0]              blue_prod_reg;
    logic [pbnc_pkg::NORM_W-1:0]    norm1_reg;
    logic [IDX_W-1:0]               idx1_reg;
    logic                           v1_reg;
    logic signed [ERR_W-1:0]        err_reg;
    logic [IDX_W-1:0]               idx2_reg;
    logic                           v2_reg;
    logic signed [ERR_W-1:0]        best_err_reg;
    logic [IDX_W-1:0]               best_idx_reg;
    logic                           best_valid_reg;
    logic [DOT_W-1:0]               dot;
    logic [SH_W-1:0]                norm_sh;
    logic signed [ERR_W-1:0]        err_next;
    logic                           take;

    // Stage 1: three channel multipliers, shared by mixing and searching
    always_ff @(posedge clk)
    begin
        red_prod_reg   <= PROD_W'(op_rgb[2*CW +: CW]) * PROD_W'(op_red);
        green_prod_reg <= PROD_W'(op_rgb[CW +: CW]) * PROD_W'(op_green);
        blue_prod_reg  <= PROD_W'(op_rgb[0 +: CW]) * PROD_W'(op_blue);
        norm1_reg      <= op_norm;
        idx1_reg       <= op_idx;
    end

    // Stage 2: scaled norm minus dot product
    assign dot = {2'b00, red_prod_reg} + {2'b00, green_prod_reg} + {2'b00, blue_prod_reg};
    assign norm_sh = {norm1_reg, {(WEIGHT_BITS-1){1'b0}}};
    assign err_next = $signed(ERR_W'(norm_sh)) - $signed(ERR_W'(dot));

    always_ff @(posedge clk)
    begin
        err_reg  <= err_next;
        idx2_reg <= idx1_reg;
    end

    // Stage 3: keep the first strictly smaller error
    assign take = v2_reg && (!best_valid_reg || (err_reg < best_err_reg));

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            best_err_reg <= err_reg;
            best_idx_reg <= idx2_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            best_valid_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= ctrl.search;
            v2_reg <= v1_reg;
            if (ctrl.clear)
            begin
                best_valid_reg <= 1'b0;
            end
            else if (take)
            begin
                best_valid_reg <= 1'b1;
            end
        end
    end

    assign red_prod   = red_prod_reg;
    assign green_prod = green_prod_reg;
    assign blue_prod  = blue_prod_reg;
    assign busy       = v1_reg | v2_reg;
    assign best_idx   = best_idx_reg;

endmodule

`default_nettype wire

// ===== tb/palette_blend_nearest_color_tb.sv =====
`default_nettype none

module palette_blend_nearest_color_tb;

    localparam int PAL_ENTRIES  = pbnc_pkg::PALETTE_SIZE_DEF;
    localparam int MIX_BITS     = pbnc_pkg::WEIGHT_BITS_DEF;
    // One full palette scan plus pipeline slack
    localparam int DRAIN_CYCLES = pbnc_pkg::PALETTE_SIZE_DEF + 16;
    localparam int RANDOM_ITEMS = 142;
    localparam int PHASES       = 9;
    localparam int MAX_REPORTS  = 10;
    localparam int DIRECTED_ROWS = 23;
    localparam longint TIMEOUT  = 64'd60_000_000;

    typedef enum logic [1:0] {
        ROW_LOAD,
        ROW_QUERY,
        ROW_PCT
    } row_op_t;

    // sel_a: entry index (load), top color (query) or percent (register write)
    typedef struct packed {
        row_op_t     op;
        logic [7:0]  sel_a;
        logic [7:0]  sel_b;
        logic [23:0] rgb;
        logic        has_want;
        logic [7:0]  want;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [pbnc_pkg::PCT_W-1:0] cfg_wdata;

    pbnc_item_if   item_ch ();
    pbnc_result_if result_ch ();

    // Shadow copy of the palette and the blend register
    logic [pbnc_pkg::RGB_W-1:0]  shadow_rgb  [PAL_ENTRIES];
    logic [pbnc_pkg::NORM_W-1:0] shadow_norm [PAL_ENTRIES];
    logic [pbnc_pkg::PCT_W-1:0]  shadow_pct;

    logic [pbnc_pkg::COLOR_W-1:0] expected_colors [$];
    int fail_count = 0;
    int src_idle_pct = 7;
    int sink_stall_pct = 86;

    int           src_idle_plan   [3]      = '{7, 86, 0};
    int           sink_stall_plan [3]      = '{86, 7, 0};
    logic [pbnc_pkg::PCT_W-1:0] pct_plan [PHASES] = '{7'd0, 7'd100, 7'd127, 7'd1, 7'd50,
                                                      7'd99, 7'd101, 7'd33, 7'd66};

    // Palette is preloaded as a grey ramp: entry i = (i, i, i)
    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        '{ROW_QUERY, 8'd0,   8'd0,   24'h000000, 1'b1, 8'd0},
        '{ROW_QUERY, 8'd255, 8'd255, 24'h000000, 1'b1, 8'd255},
        '{ROW_QUERY, 8'd128, 8'd128, 24'h000000, 1'b1, 8'd128},
        '{ROW_QUERY, 8'd0,   8'd255, 24'h000000, 1'b0, 8'd0},
        '{ROW_QUERY, 8'd255, 8'd0,   24'h000000, 1'b0, 8'd0},
        // second black entry: tie on black goes to the higher index
        '{ROW_LOAD,  8'd200, 8'd0,   24'h000000, 1'b0, 8'd0},
        '{ROW_QUERY, 8'd0,   8'd0,   24'h000000, 1'b1, 8'd200},
        // second white entry below 255: tie stays on 255
        '{ROW_LOAD,  8'd3,   8'd0,   24'hFFFFFF, 1'b0, 8'd0},
        '{ROW_QUERY, 8'd255, 8'd255, 24'h000000, 1'b1, 8'd255},
        '{ROW_LOAD,  8'd9,   8'd0,   24'hFF0000, 1'b0, 8'd0},
        '{ROW_LOAD,  8'd10,  8'd0,   24'h00FF00, 1'b0, 8'd0},
        '{ROW_LOAD,  8'd11,  8'd0,   24'h0000FF, 1'b0, 8'd0},
        '{ROW_QUERY, 8'd9,   8'd10,  24'h000000, 1'b0, 8'd0},
        '{ROW_QUERY, 8'd11,  8'd9,   24'h000000, 1'b0, 8'd0},
        // zero percent: bottom color only
        '{ROW_PCT,   8'd0,   8'd0,   24'h000000, 1'b0, 8'd0},
        '{ROW_QUERY, 8'd5,   8'd77,  24'h000000, 1'b1, 8'd77},
        '{ROW_QUERY, 8'd9,   8'd200, 24'h000000, 1'b0, 8'd0},
        // full percent: top color only
        '{ROW_PCT,   8'd100, 8'd0,   24'h000000, 1'b0, 8'd0},
        '{ROW_QUERY, 8'd5,   8'd77,  24'h000000, 1'b1, 8'd5},
        // percent above 100 saturates
        '{ROW_PCT,   8'd127, 8'd0,   24'h000000, 1'b0, 8'd0},
        '{ROW_QUERY, 8'd77,  8'd5,   24'h000000, 1'b1, 8'd77},
        '{ROW_PCT,   8'd101, 8'd0,   24'h000000, 1'b0, 8'd0},
        '{ROW_QUERY, 8'd20,  8'd30,  24'h000000, 1'b1, 8'd20}
    };

    palette_blend_nearest_color u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Mix two shadow entries and search the shadow palette, highest index first
    function automatic logic [pbnc_pkg::COLOR_W-1:0] nearest_blend_color(
        input logic [pbnc_pkg::COLOR_W-1:0] top,
        input logic [pbnc_pkg::COLOR_W-1:0] bottom
    );
        logic [pbnc_pkg::PCT_W-1:0] pct;
        logic [pbnc_pkg::RGB_W-1:0] top_rgb;
        logic [pbnc_pkg::RGB_W-1:0] bot_rgb;
        longint w_top;
        longint w_bot;
        longint mix_r;
        longint mix_g;
        longint mix_b;
        longint dot;
        longint err;
        longint best;
        logic [pbnc_pkg::COLOR_W-1:0] best_idx;
        int c;
        pct = (shadow_pct > pbnc_pkg::PERCENT_MAX) ? pbnc_pkg::PERCENT_MAX : shadow_pct;
        w_top = (longint'(pct) << MIX_BITS) / longint'(pbnc_pkg::PERCENT_MAX);
        w_bot = (longint'(1) << MIX_BITS) - w_top;
        top_rgb = shadow_rgb[top];
        bot_rgb = shadow_rgb[bottom];
        mix_r = longint'(top_rgb[23:16]) * w_top + longint'(bot_rgb[23:16]) * w_bot;
        mix_g = longint'(top_rgb[15:8]) * w_top + longint'(bot_rgb[15:8]) * w_bot;
        mix_b = longint'(top_rgb[7:0]) * w_top + longint'(bot_rgb[7:0]) * w_bot;
        best = 64'sh7FFF_FFFF_FFFF_FFFF;
        best_idx = '0;
        for (c = PAL_ENTRIES - 1; c >= 0; c--)
        begin
            dot = longint'(shadow_rgb[c][23:16]) * mix_r
                + longint'(shadow_rgb[c][15:8]) * mix_g
                + longint'(shadow_rgb[c][7:0]) * mix_b;
            err = (longint'(shadow_norm[c]) << (MIX_BITS - 1)) - dot;
            if (err < best)
            begin
                best = err;
                best_idx = pbnc_pkg::COLOR_W'(c);
            end
        end
        return best_idx;
    endfunction

    task automatic note_failure(input string msg);
        if (fail_count < MAX_REPORTS)
            $display("ERROR at %0t: %s", $realtime, msg);
        fail_count++;
    endtask

    // Drive one item, wait for acceptance, then update the shadow state or queue the expected color
    task automatic send_item(
        input logic                         kind,
        input logic [pbnc_pkg::COLOR_W-1:0] sel_a,
        input logic [pbnc_pkg::COLOR_W-1:0] sel_b,
        input logic [pbnc_pkg::RGB_W-1:0]   rgb,
        input logic                         has_want,
        input logic [pbnc_pkg::COLOR_W-1:0] want
    );
        logic [pbnc_pkg::RGB_W-1:0] junk_rgb;
        junk_rgb = pbnc_pkg::RGB_W'($urandom);
        // hold off for a random gap
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            item_ch.valid <= 1'b0;
            @(negedge clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.kind  <= kind;
        // unused fields carry junk
        if (kind == pbnc_pkg::KIND_LOAD)
        begin
            item_ch.entry_index  <= sel_a;
            item_ch.red          <= rgb[23:16];
            item_ch.green        <= rgb[15:8];
            item_ch.blue         <= rgb[7:0];
            item_ch.top_color    <= pbnc_pkg::COLOR_W'($urandom);
            item_ch.bottom_color <= pbnc_pkg::COLOR_W'($urandom);
        end
        else
        begin
            item_ch.entry_index  <= pbnc_pkg::COLOR_W'($urandom);
            item_ch.red          <= junk_rgb[23:16];
            item_ch.green        <= junk_rgb[15:8];
            item_ch.blue         <= junk_rgb[7:0];
            item_ch.top_color    <= sel_a;
            item_ch.bottom_color <= sel_b;
        end
        do
            @(posedge clk);
        while (item_ch.ready !== 1'b1);
        if (kind == pbnc_pkg::KIND_LOAD)
        begin
            shadow_rgb[sel_a]  = rgb;
            shadow_norm[sel_a] = pbnc_pkg::NORM_W'(rgb[23:16]) * pbnc_pkg::NORM_W'(rgb[23:16])
                               + pbnc_pkg::NORM_W'(rgb[15:8]) * pbnc_pkg::NORM_W'(rgb[15:8])
                               + pbnc_pkg::NORM_W'(rgb[7:0]) * pbnc_pkg::NORM_W'(rgb[7:0]);
        end
        else if (has_want)
            expected_colors.push_back(want);
        else
            expected_colors.push_back(nearest_blend_color(sel_a, sel_b));
        @(negedge clk);
    endtask

    // Write filter_percent once the block has gone idle
    task automatic set_blend_percent(input logic [pbnc_pkg::PCT_W-1:0] pct);
        item_ch.valid <= 1'b0;
        while (expected_colors.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= pct;
        @(negedge clk);
        cfg_we     <= 1'b0;
        shadow_pct = pct;
    endtask

    // Randomly stall the result channel
    always @(negedge clk)
    begin
        result_ch.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    // Compare each accepted result with the oldest expected color
    always @(posedge clk)
    begin
        logic [pbnc_pkg::COLOR_W-1:0] want_color;
        if (rst_n && result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
        begin
            if (expected_colors.size() == 0)
                note_failure($sformatf("unexpected result blended_color=%0d",
                                       result_ch.blended_color));
            else
            begin
                want_color = expected_colors.pop_front();
                if (result_ch.blended_color !== want_color)
                    note_failure($sformatf("blended_color expected %0d, got %0d",
                                           want_color, result_ch.blended_color));
            end
        end
    end

    initial
    begin
        #(TIMEOUT);
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        stim_row_t row;
        logic [pbnc_pkg::RGB_W-1:0] rgb;
        logic [pbnc_pkg::COLOR_W-1:0] top;
        logic [pbnc_pkg::COLOR_W-1:0] bottom;
        int i;
        int phase;
        int ch;
        int pick;

        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_wdata            = '0;
        item_ch.valid        = 1'b0;
        item_ch.kind         = pbnc_pkg::KIND_LOAD;
        item_ch.entry_index  = '0;
        item_ch.red          = '0;
        item_ch.green        = '0;
        item_ch.blue         = '0;
        item_ch.top_color    = '0;
        item_ch.bottom_color = '0;
        result_ch.ready      = 1'b0;
        shadow_pct           = pbnc_pkg::PERCENT_RESET;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Fill the whole palette with a grey ramp before any query
        for (i = 0; i < PAL_ENTRIES; i++)
            send_item(pbnc_pkg::KIND_LOAD, pbnc_pkg::COLOR_W'(i), '0,
                      {3{pbnc_pkg::COLOR_W'(i)}}, 1'b0, '0);

        // Directed rows
        for (i = 0; i < DIRECTED_ROWS; i++)
        begin
            row = directed_rows[i];
            case (row.op)
                ROW_LOAD:  send_item(pbnc_pkg::KIND_LOAD, row.sel_a, row.sel_b, row.rgb,
                                     1'b0, '0);
                ROW_QUERY: send_item(pbnc_pkg::KIND_QUERY, row.sel_a, row.sel_b, row.rgb,
                                     row.has_want, row.want);
                default:   set_blend_percent(row.sel_a[pbnc_pkg::PCT_W-1:0]);
            endcase
        end

        // Random loads and queries over several blend settings and idle mixes
        for (phase = 0; phase < PHASES; phase++)
        begin
            set_blend_percent(pct_plan[phase]);
            src_idle_pct   = src_idle_plan[phase / 3];
            sink_stall_pct = sink_stall_plan[phase / 3];
            for (i = 0; i < RANDOM_ITEMS; i++)
            begin
                if ($urandom_range(0, 99) < 35)
                begin
                    pick = $urandom_range(0, 99);
                    rgb  = pbnc_pkg::RGB_W'($urandom);
                    if (pick < 20)
                        // copy an existing color to provoke ties
                        rgb = shadow_rgb[$urandom_range(0, PAL_ENTRIES - 1)];
                    else if (pick < 35)
                    begin
                        for (ch = 0; ch < 3; ch++)
                        begin
                            case ($urandom_range(0, 2))
                                0:       rgb[8*ch +: 8] = 8'h00;
                                1:       rgb[8*ch +: 8] = 8'hFF;
                                default: rgb[8*ch +: 8] = pbnc_pkg::COLOR_W'($urandom);
                            endcase
                        end
                    end
                    send_item(pbnc_pkg::KIND_LOAD, pbnc_pkg::COLOR_W'($urandom), '0, rgb,
                              1'b0, '0);
                end
                else
                begin
                    top    = pbnc_pkg::COLOR_W'($urandom);
                    bottom = ($urandom_range(0, 99) < 15) ? top : pbnc_pkg::COLOR_W'($urandom);
                    send_item(pbnc_pkg::KIND_QUERY, top, bottom, '0, 1'b0, '0);
                end
            end
        end

        // Drain outstanding results, then allow time for stray ones
        item_ch.valid <= 1'b0;
        while (expected_colors.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (fail_count == 0 && expected_colors.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire
